/* design/gss_pkg.sv */
// shared constants for the golden-section search unit
`default_nettype none

package gss_pkg;

    // golden-section ratio 0.381966011 as a Q0.32 constant
    localparam logic [31:0] GOLD_Q32 = 32'd1640531525;

    // fixed field widths
    localparam int TOL_WIDTH  = 31;
    localparam int ITER_WIDTH = 6;
    localparam int EVAL_WIDTH = 7;
    localparam logic [EVAL_WIDTH-1:0] EVAL_MAX = 7'd127;

    // configuration register indexes
    localparam logic [1:0] CFG_LEFT_START  = 2'd0;
    localparam logic [1:0] CFG_RIGHT_START = 2'd1;
    localparam logic [1:0] CFG_TOLERANCE   = 2'd2;

    // configuration reset values
    localparam logic signed [47:0] LEFT_START_RESET  = -48'sd131072;
    localparam logic signed [47:0] RIGHT_START_RESET = 48'sd1310720;
    localparam logic [TOL_WIDTH-1:0] TOLERANCE_RESET = 31'd6554;

    // search phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_FIRST = 2'd1;
    localparam logic [1:0] PH_LOW   = 2'd2;
    localparam logic [1:0] PH_HIGH  = 2'd3;

endpackage

`default_nettype wire

/* design/golden_section_search_unit.sv */
// golden-section minimum search, top level
//
// Input channel (i_in_valid / o_in_ready) takes one word per cycle: mode 0 starts a
// search over the configured interval, mode 1 delivers the objective value at the
// last point asked for. Every input word yields exactly one result word on the
// output channel (o_out_valid / i_out_ready): the next query point, the done and
// cap flags, the current interval and the step and evaluation counters.
// A word accepted at an edge sits in the input register; when the result register
// is empty or being taken, the interval update (one compare, one subtract, one
// constant multiply per candidate interval, one add) writes the search state and
// the result register, which offers the result word from then on.
// Throughput is one word per cycle; the external evaluator sets the real pace.
// When the receiver stalls, the result register holds and the input register
// fills; o_in_ready drops only while both are occupied and the result is not taken.
// Configuration writes (i_cfg_we) take effect on the next edge; the user must make
// them only while no word is in flight (not enforced). Synchronous reset empties
// both registers, idles the search, zeroes bounds and counters, and restores the
// configuration defaults; a value word while idle repeats the last final result.
`default_nettype none

module golden_section_search_unit #(
    parameter int COORD_WIDTH    = 32,
    parameter int VALUE_WIDTH    = 48,
    parameter int MAX_ITERATIONS = 63
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_index,
    input  logic [((COORD_WIDTH > 31) ? COORD_WIDTH : 31)-1:0] i_cfg_data,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_mode,
    input  logic signed [VALUE_WIDTH-1:0]   i_objective_value,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [COORD_WIDTH-1:0]   o_query_point,
    output logic                            o_is_done,
    output logic                            o_hit_cap,
    output logic signed [COORD_WIDTH-1:0]   o_left_end,
    output logic signed [COORD_WIDTH-1:0]   o_right_end,
    output logic [gss_pkg::ITER_WIDTH-1:0]  o_iterations,
    output logic [gss_pkg::EVAL_WIDTH-1:0]  o_evaluations
);

    localparam int CW   = COORD_WIDTH;
    localparam int CX   = COORD_WIDTH + 1;
    localparam int VW   = VALUE_WIDTH;
    localparam int SW   = $clog2(MAX_ITERATIONS + 1);
    localparam int CMPW = COORD_WIDTH + 32;
    localparam int IW   = gss_pkg::ITER_WIDTH;
    localparam int EW   = gss_pkg::EVAL_WIDTH;

    // configuration registers
    logic signed [CW-1:0]                r_left_start;
    logic signed [CW-1:0]                r_right_start;
    logic [gss_pkg::TOL_WIDTH-1:0]       r_tolerance;

    // input register
    logic                                r_in_valid;
    logic                                r_in_mode;
    logic signed [VW-1:0]                r_in_value;

    // search state
    logic signed [CW-1:0]                r_left_bound,  n_left_bound;
    logic signed [CW-1:0]                r_right_bound, n_right_bound;
    logic signed [CW-1:0]                r_inner_low,   n_inner_low;
    logic signed [CW-1:0]                r_inner_high,  n_inner_high;
    logic signed [VW-1:0]                r_value_low,   n_value_low;
    logic signed [VW-1:0]                r_value_high,  n_value_high;
    logic [1:0]                          r_phase,       n_phase;
    logic [SW-1:0]                       r_step,        n_step;
    logic [EW-1:0]                       r_eval,        n_eval;
    logic                                r_capped,      n_capped;

    // result register
    logic                                r_out_valid;
    logic signed [CW-1:0]                r_out_query,   n_out_query;
    logic                                r_out_done,    n_out_done;

    // handshake
    logic                                w_out_adv;
    logic                                w_fire;
    logic                                w_in_acc;

    // datapath
    logic signed [CX-1:0]                w_diff_a;
    logic signed [CX-1:0]                w_diff_b;
    logic signed [CX-1:0]                w_off_a;
    logic signed [CX-1:0]                w_off_b;
    logic signed [CX-1:0]                w_span;
    logic [CX-1:0]                       w_width;
    logic                                w_in_tol;
    logic                                w_at_cap;
    logic signed [VW-1:0]                w_vl;
    logic signed [VW-1:0]                w_vh;
    logic signed [CX-1:0]                w_start_lo;
    logic signed [CX-1:0]                w_start_hi;
    logic signed [CX-1:0]                w_step_lo;
    logic signed [CX-1:0]                w_step_hi;
    logic [EW-1:0]                       w_eval_inc;
    logic [SW+IW-1:0]                    w_step_ext;

    // pipeline flow control
    assign w_out_adv  = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_out_adv;
    assign o_in_ready = !r_in_valid || w_out_adv;
    assign w_in_acc   = i_in_valid && o_in_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_start  <= CW'(gss_pkg::LEFT_START_RESET);
            r_right_start <= CW'(gss_pkg::RIGHT_START_RESET);
            r_tolerance   <= gss_pkg::TOLERANCE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gss_pkg::CFG_LEFT_START:  r_left_start  <= i_cfg_data[CW-1:0];
                gss_pkg::CFG_RIGHT_START: r_right_start <= i_cfg_data[CW-1:0];
                gss_pkg::CFG_TOLERANCE:   r_tolerance   <= i_cfg_data[gss_pkg::TOL_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_mode  <= i_mode;
            r_in_value <= i_objective_value;
        end
    end

    // offset operands: start interval or the kept-left candidate, and the kept-right one
    assign w_diff_a = r_in_mode ? (CX'(r_inner_high) - CX'(r_left_bound))
                                : (CX'(r_right_start) - CX'(r_left_start));
    assign w_diff_b = CX'(r_right_bound) - CX'(r_inner_low);

    gss_offset #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_offset_a (
        .i_diff   (w_diff_a),
        .o_offset (w_off_a)
    );

    gss_offset #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_offset_b (
        .i_diff   (w_diff_b),
        .o_offset (w_off_b)
    );

    // stop checks on the current interval
    assign w_span   = CX'(r_right_bound) - CX'(r_left_bound);
    assign w_width  = w_span[CX-1] ? (~w_span + 1'b1) : w_span;
    assign w_in_tol = CMPW'(w_width) <= CMPW'(r_tolerance);
    assign w_at_cap = r_step >= SW'(MAX_ITERATIONS);

    // value pair once the awaited value is in
    assign w_vl = (r_phase == gss_pkg::PH_LOW)  ? r_in_value : r_value_low;
    assign w_vh = (r_phase == gss_pkg::PH_HIGH) ? r_in_value : r_value_high;

    // candidate interior points
    assign w_start_lo = CX'(r_left_start) + w_off_a;
    assign w_start_hi = CX'(r_right_start) - w_off_a;
    assign w_step_lo  = CX'(r_left_bound) + w_off_a;
    assign w_step_hi  = CX'(r_right_bound) - w_off_b;

    assign w_eval_inc = (r_eval == gss_pkg::EVAL_MAX) ? r_eval : r_eval + 1'b1;

    // next search state and result
    always_comb begin
        n_left_bound  = r_left_bound;
        n_right_bound = r_right_bound;
        n_inner_low   = r_inner_low;
        n_inner_high  = r_inner_high;
        n_value_low   = r_value_low;
        n_value_high  = r_value_high;
        n_phase       = r_phase;
        n_step        = r_step;
        n_eval        = r_eval;
        n_capped      = r_capped;
        n_out_query   = '0;
        n_out_done    = 1'b1;
        if (!r_in_mode) begin
            n_left_bound  = r_left_start;
            n_right_bound = r_right_start;
            n_inner_low   = w_start_lo[CW-1:0];
            n_inner_high  = w_start_hi[CW-1:0];
            n_value_low   = '0;
            n_value_high  = '0;
            n_step        = '0;
            n_eval        = EW'(1);
            n_capped      = 1'b0;
            n_phase       = gss_pkg::PH_FIRST;
            n_out_query   = w_start_lo[CW-1:0];
            n_out_done    = 1'b0;
        end else begin
            case (r_phase)
                gss_pkg::PH_FIRST: begin
                    n_value_low = r_in_value;
                    n_eval      = w_eval_inc;
                    n_phase     = gss_pkg::PH_HIGH;
                    n_out_query = r_inner_high;
                    n_out_done  = 1'b0;
                end
                gss_pkg::PH_LOW, gss_pkg::PH_HIGH: begin
                    n_value_low  = w_vl;
                    n_value_high = w_vh;
                    if (w_in_tol) begin
                        n_phase = gss_pkg::PH_IDLE;
                    end else if (w_at_cap) begin
                        n_capped = 1'b1;
                        n_phase  = gss_pkg::PH_IDLE;
                    end else begin
                        n_step     = r_step + 1'b1;
                        n_eval     = w_eval_inc;
                        n_out_done = 1'b0;
                        if (w_vl < w_vh) begin
                            // keep [a, x2]
                            n_right_bound = r_inner_high;
                            n_inner_high  = r_inner_low;
                            n_value_high  = w_vl;
                            n_inner_low   = w_step_lo[CW-1:0];
                            n_phase       = gss_pkg::PH_LOW;
                            n_out_query   = w_step_lo[CW-1:0];
                        end else begin
                            // keep [x1, b]
                            n_left_bound  = r_inner_low;
                            n_inner_low   = r_inner_high;
                            n_value_low   = w_vh;
                            n_inner_high  = w_step_hi[CW-1:0];
                            n_phase       = gss_pkg::PH_HIGH;
                            n_out_query   = w_step_hi[CW-1:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // search state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_bound  <= '0;
            r_right_bound <= '0;
            r_inner_low   <= '0;
            r_inner_high  <= '0;
            r_value_low   <= '0;
            r_value_high  <= '0;
            r_phase       <= gss_pkg::PH_IDLE;
            r_step        <= '0;
            r_eval        <= '0;
            r_capped      <= 1'b0;
        end else if (w_fire) begin
            r_left_bound  <= n_left_bound;
            r_right_bound <= n_right_bound;
            r_inner_low   <= n_inner_low;
            r_inner_high  <= n_inner_high;
            r_value_low   <= n_value_low;
            r_value_high  <= n_value_high;
            r_phase       <= n_phase;
            r_step        <= n_step;
            r_eval        <= n_eval;
            r_capped      <= n_capped;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_query <= n_out_query;
            r_out_done  <= n_out_done;
        end
    end

    // outputs: bounds, the cap flag and counters come straight from the search state
    assign w_step_ext    = {{IW{1'b0}}, r_step};
    assign o_out_valid   = r_out_valid;
    assign o_query_point = r_out_query;
    assign o_is_done     = r_out_done;
    assign o_hit_cap     = r_capped;
    assign o_left_end    = r_left_bound;
    assign o_right_end   = r_right_bound;
    assign o_iterations  = w_step_ext[IW-1:0];
    assign o_evaluations = r_eval;

endmodule

`default_nettype wire

/* design/gss_offset.sv */
// golden-section offset: round(|d| * c) carrying the sign of d
`default_nettype none

module gss_offset #(
    parameter int COORD_WIDTH = 32
) (
    input  logic signed [COORD_WIDTH:0] i_diff,
    output logic signed [COORD_WIDTH:0] o_offset
);

    localparam int CX = COORD_WIDTH + 1;
    localparam int PW = COORD_WIDTH + 33;

    logic [CX-1:0] w_mag;
    logic [PW-1:0] w_prod;
    logic [CX-1:0] w_mag_off;
    logic [CX-1:0] w_res;

    // magnitude of the difference
    assign w_mag = i_diff[COORD_WIDTH] ? (~i_diff + 1'b1) : i_diff;

    // scale by c, round half up, drop the 32 fraction bits
    assign w_prod    = PW'(w_mag) * PW'(gss_pkg::GOLD_Q32) + (PW'(1) << 31);
    assign w_mag_off = w_prod[PW-1:32];

    // restore the sign
    assign w_res    = i_diff[COORD_WIDTH] ? (~w_mag_off + 1'b1) : w_mag_off;
    assign o_offset = $signed(w_res);

endmodule

`default_nettype wire

/* verif/tb_golden_section_search_unit.sv */
// testbench for the golden-section search unit: directed table plus random searches
`timescale 1ns / 100ps

module tb_golden_section_search_unit;

    localparam int STEP_CAP     = 63;
    localparam int RANDOM_WORDS = 850;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_VALUE = 1'b1;

    localparam logic signed [47:0] VALUE_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] VALUE_MIN = 48'sh8000_0000_0000;
    localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] COORD_MIN = 32'h8000_0000;
    localparam logic [31:0] TOL_TOP   = 32'h7FFF_FFFF;

    typedef struct {
        logic signed [31:0] query;
        logic               done;
        logic               cap;
        logic signed [31:0] left_end;
        logic signed [31:0] right_end;
        logic [5:0]         iters;
        logic [6:0]         evals;
    } t_search_result;

    typedef enum logic {ROW_WORD, ROW_SETTING} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic               mode;
        logic signed [47:0] value;
        logic [1:0]         cfg_idx;
        logic [31:0]        cfg_data;
        bit                 pinned;
        t_search_result     result;
    } t_plan_row;

    typedef enum int {OBJ_BOWL, OBJ_VEE, OBJ_NOISE, OBJ_FLAT} t_obj_shape;

    // clock, reset and block inputs
    logic               i_clk;
    logic               i_rst_n           = 1'b0;
    logic               i_cfg_we          = 1'b0;
    logic [1:0]         i_cfg_index       = gss_pkg::CFG_LEFT_START;
    logic [31:0]        i_cfg_data        = '0;
    logic               i_in_valid        = 1'b0;
    logic               i_mode            = MODE_START;
    logic signed [47:0] i_objective_value = '0;
    logic               i_out_ready       = 1'b0;

    // block outputs
    logic               o_in_ready;
    logic               o_out_valid;
    logic signed [31:0] o_query_point;
    logic               o_is_done;
    logic               o_hit_cap;
    logic signed [31:0] o_left_end;
    logic signed [31:0] o_right_end;
    logic [5:0]         o_iterations;
    logic [6:0]         o_evaluations;

    // shadow configuration and search state
    longint          cfg_left;
    longint          cfg_right;
    longint unsigned cfg_tol;
    longint          seg_left;
    longint          seg_right;
    longint          probe_low;
    longint          probe_high;
    longint          f_low;
    longint          f_high;
    logic [1:0]      srch_phase;
    int unsigned     srch_steps;
    int unsigned     srch_evals;
    bit              srch_capped;

    // expected result words, oldest first
    t_search_result  pending_results[$];
    t_search_result  last_pred;
    t_search_result  oldest;
    t_search_result  no_pin;
    t_plan_row       plan[$];

    // current objective shape
    t_obj_shape      obj_shape;
    longint          obj_center;
    longint          obj_slope;
    longint          obj_offset;
    bit              obj_flip;

    // idling control
    bit              in_burst  = 1'b0;
    bit              out_burst = 1'b0;
    int unsigned     out_hold  = 0;

    // bookkeeping
    int unsigned     mismatches        = 0;
    int unsigned     cycle_count       = 0;
    int unsigned     words_sent        = 0;
    int unsigned     directed_words    = 0;
    int unsigned     searches_started  = 0;
    int unsigned     searches_finished = 0;
    int unsigned     cap_stops         = 0;
    int unsigned     tie_steps         = 0;
    int unsigned     settings_written  = 0;
    int unsigned     phase_no          = 0;
    int unsigned     searches_left     = 0;

    golden_section_search_unit #(
        .COORD_WIDTH   (32),
        .VALUE_WIDTH   (48),
        .MAX_ITERATIONS(STEP_CAP)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_objective_value(i_objective_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_query_point    (o_query_point),
        .o_is_done        (o_is_done),
        .o_hit_cap        (o_hit_cap),
        .o_left_end       (o_left_end),
        .o_right_end      (o_right_end),
        .o_iterations     (o_iterations),
        .o_evaluations    (o_evaluations)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // round(|d| * ratio) carrying the sign of d
    function automatic longint golden_offset(longint d);
        longint unsigned mag, dh, dl, p, q, o;
        mag = (d < 0) ? 64'(-d) : 64'(d);
        dh  = mag >> 16;
        dl  = mag & 64'hFFFF;
        p   = dh * gss_pkg::GOLD_Q32;
        q   = dl * gss_pkg::GOLD_Q32 + (64'd1 << 31);
        o   = (p >> 16) + ((((p & 64'hFFFF) << 16) + q) >> 32);
        return (d < 0) ? -longint'(o) : longint'(o);
    endfunction

    function automatic t_search_result pack_result(longint q, bit asking);
        t_search_result r;
        r.query     = asking ? q[31:0] : '0;
        r.done      = !asking;
        r.cap       = srch_capped;
        r.left_end  = seg_left[31:0];
        r.right_end = seg_right[31:0];
        r.iters     = srch_steps[5:0];
        r.evals     = srch_evals[6:0];
        return r;
    endfunction

    // queue a result word as expected
    function automatic void expect_word(t_search_result r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // append one row to the directed table
    function automatic void add_row(t_plan_row row);
        plan.insert(plan.size(), row);
    endfunction

    function automatic void reset_search_model();
        cfg_left    = gss_pkg::LEFT_START_RESET;
        cfg_right   = gss_pkg::RIGHT_START_RESET;
        cfg_tol     = gss_pkg::TOLERANCE_RESET;
        seg_left    = 0;
        seg_right   = 0;
        probe_low   = 0;
        probe_high  = 0;
        f_low       = 0;
        f_high      = 0;
        srch_phase  = gss_pkg::PH_IDLE;
        srch_steps  = 0;
        srch_evals  = 0;
        srch_capped = 1'b0;
    endfunction

    // both values known: stop, or shrink the interval and ask one new point
    function automatic t_search_result reduce_interval();
        longint          d;
        longint unsigned span;
        d    = seg_right - seg_left;
        span = (d < 0) ? 64'(-d) : 64'(d);
        if (span <= cfg_tol) begin
            srch_phase = gss_pkg::PH_IDLE;
            searches_finished++;
            return pack_result(0, 1'b0);
        end
        if (srch_steps >= STEP_CAP) begin
            srch_capped = 1'b1;
            srch_phase  = gss_pkg::PH_IDLE;
            searches_finished++;
            cap_stops++;
            return pack_result(0, 1'b0);
        end
        srch_steps++;
        if (srch_evals < gss_pkg::EVAL_MAX) srch_evals++;
        if (f_low == f_high) tie_steps++;
        if (f_low < f_high) begin
            seg_right  = probe_high;
            probe_high = probe_low;
            f_high     = f_low;
            probe_low  = seg_left + golden_offset(seg_right - seg_left);
            srch_phase = gss_pkg::PH_LOW;
            return pack_result(probe_low, 1'b1);
        end
        seg_left   = probe_low;
        probe_low  = probe_high;
        f_low      = f_high;
        probe_high = seg_right - golden_offset(seg_right - seg_left);
        srch_phase = gss_pkg::PH_HIGH;
        return pack_result(probe_high, 1'b1);
    endfunction

    // result word caused by one accepted input word
    function automatic t_search_result predict_word(logic mode, logic signed [47:0] val);
        longint off;
        if (mode == MODE_START) begin
            seg_left    = cfg_left;
            seg_right   = cfg_right;
            off         = golden_offset(seg_right - seg_left);
            probe_low   = seg_left + off;
            probe_high  = seg_right - off;
            f_low       = 0;
            f_high      = 0;
            srch_steps  = 0;
            srch_evals  = 1;
            srch_capped = 1'b0;
            srch_phase  = gss_pkg::PH_FIRST;
            searches_started++;
            return pack_result(probe_low, 1'b1);
        end
        case (srch_phase)
            gss_pkg::PH_FIRST: begin
                f_low = longint'(val);
                if (srch_evals < gss_pkg::EVAL_MAX) srch_evals++;
                srch_phase = gss_pkg::PH_HIGH;
                return pack_result(probe_high, 1'b1);
            end
            gss_pkg::PH_LOW: begin
                f_low = longint'(val);
                return reduce_interval();
            end
            gss_pkg::PH_HIGH: begin
                f_high = longint'(val);
                return reduce_interval();
            end
            default: return pack_result(0, 1'b0);
        endcase
    endfunction

    function automatic logic signed [47:0] random_value();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[47:0];
    endfunction

    // objective seen by the block at point x
    function automatic logic signed [47:0] objective_at(longint x);
        longint d, mag, v;
        if ($urandom_range(0, 19) == 0) return random_value();
        d   = x - obj_center;
        mag = (d < 0) ? -d : d;
        case (obj_shape)
            OBJ_BOWL:  v = (mag >>> 10) * (mag >>> 10);
            OBJ_VEE:   v = mag * obj_slope;
            OBJ_NOISE: return random_value();
            default:   v = 0;
        endcase
        if (obj_flip) v = -v;
        v = v + obj_offset;
        return v[47:0];
    endfunction

    function automatic t_search_result outcome(logic signed [31:0] q, logic done,
                                               logic [31:0] l, logic [31:0] r,
                                               logic [6:0] evals);
        t_search_result res;
        res.query     = q;
        res.done      = done;
        res.cap       = 1'b0;
        res.left_end  = l;
        res.right_end = r;
        res.iters     = '0;
        res.evals     = evals;
        return res;
    endfunction

    function automatic t_plan_row word_row(logic mode, logic signed [47:0] value);
        t_plan_row row;
        row.kind     = ROW_WORD;
        row.mode     = mode;
        row.value    = value;
        row.cfg_idx  = gss_pkg::CFG_LEFT_START;
        row.cfg_data = '0;
        row.pinned   = 1'b0;
        row.result   = no_pin;
        return row;
    endfunction

    function automatic t_plan_row checked_row(logic mode, logic signed [47:0] value,
                                              t_search_result r);
        t_plan_row row;
        row        = word_row(mode, value);
        row.pinned = 1'b1;
        row.result = r;
        return row;
    endfunction

    function automatic t_plan_row setting_row(logic [1:0] idx, logic [31:0] data);
        t_plan_row row;
        row          = word_row(MODE_VALUE, '0);
        row.kind     = ROW_SETTING;
        row.cfg_idx  = idx;
        row.cfg_data = data;
        return row;
    endfunction

    task automatic report_mismatch(string what, logic signed [63:0] got,
                                   logic signed [63:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
    endtask

    // present one word and hold it until taken; valid stays high on return
    task automatic send_word(logic mode, logic signed [47:0] value, bit pinned,
                             t_search_result pin);
        int unsigned    gap;
        t_search_result res;
        gap = in_burst ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_mode            <= mode;
        i_objective_value <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        res       = predict_word(mode, value);
        last_pred = res;
        expect_word(pinned ? pin : res);
        words_sent++;
    endtask

    // register write once nothing is in flight
    task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            gss_pkg::CFG_LEFT_START:  cfg_left  = longint'(signed'(data));
            gss_pkg::CFG_RIGHT_START: cfg_right = longint'(signed'(data));
            gss_pkg::CFG_TOLERANCE:   cfg_tol   = data[30:0];
            default: ;
        endcase
        settings_written++;
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return $urandom;
            3:       return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            4:       return gss_pkg::LEFT_START_RESET[31:0];
            default: return 32'($urandom_range(0, 32'h0100_0000));
        endcase
    endfunction

    function automatic logic [31:0] pick_tolerance();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'd1;
            2, 3, 4, 5: return 32'($urandom_range(1, 65535));
            6, 7:    return 32'($urandom_range(1, 32'h0010_0000));
            8:       return {1'b0, raw[30:0]};
            default: return TOL_TOP;
        endcase
    endfunction

    // one search with a random objective, sometimes broken off or padded with strays
    task automatic run_search();
        int unsigned asked, quit_after;
        obj_shape  = t_obj_shape'($urandom_range(0, 3));
        obj_center = longint'(int'($urandom));
        obj_slope  = $urandom_range(0, 8191);
        obj_flip   = ($urandom_range(0, 3) == 0);
        obj_offset = (longint'($urandom) - 64'sd2147483648) <<< $urandom_range(0, 14);
        in_burst   = ($urandom_range(0, 4) == 0);
        out_burst <= ($urandom_range(0, 4) == 0);
        quit_after = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : 200;
        if ($urandom_range(0, 9) == 0) send_word(MODE_VALUE, random_value(), 1'b0, no_pin);
        send_word(MODE_START, random_value(), 1'b0, no_pin);
        asked = 0;
        while (!last_pred.done && asked < quit_after) begin
            send_word(MODE_VALUE, objective_at(longint'(last_pred.query)), 1'b0, no_pin);
            asked++;
        end
        if ($urandom_range(0, 3) == 0) send_word(MODE_VALUE, random_value(), 1'b0, no_pin);
    endtask

    // result check and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_hold = 0;
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result word with nothing expected, query_point",
                                    o_query_point, 0);
                end else begin
                    oldest = pending_results.pop_front();
                    if (o_query_point !== oldest.query)
                        report_mismatch("query_point", o_query_point, oldest.query);
                    if (o_is_done !== oldest.done)
                        report_mismatch("is_done", o_is_done, oldest.done);
                    if (o_hit_cap !== oldest.cap)
                        report_mismatch("hit_cap", o_hit_cap, oldest.cap);
                    if (o_left_end !== oldest.left_end)
                        report_mismatch("left_end", o_left_end, oldest.left_end);
                    if (o_right_end !== oldest.right_end)
                        report_mismatch("right_end", o_right_end, oldest.right_end);
                    if (o_iterations !== oldest.iters)
                        report_mismatch("iterations", o_iterations, oldest.iters);
                    if (o_evaluations !== oldest.evals)
                        report_mismatch("evaluations", o_evaluations, oldest.evals);
                end
                out_hold = out_burst ? 0 : $urandom_range(0, 14);
            end else if (out_hold != 0) begin
                out_hold = out_hold - 1;
            end
            i_out_ready <= (out_hold == 0);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // stimulus
    initial begin
        reset_search_model();
        no_pin = outcome('0, 1'b0, '0, '0, '0);

        // idle after reset: done flag set, everything else zero
        add_row(checked_row(MODE_VALUE, '0, outcome('0, 1'b1, '0, '0, '0)));
        add_row(checked_row(MODE_VALUE, VALUE_MIN, outcome('0, 1'b1, '0, '0, '0)));
        // default interval: strict less, tie, extremes, restart mid-search
        add_row(word_row(MODE_START, VALUE_MAX));
        add_row(word_row(MODE_VALUE, 48'sd100));
        add_row(word_row(MODE_VALUE, 48'sd200));
        add_row(word_row(MODE_VALUE, 48'sd100));
        add_row(word_row(MODE_VALUE, VALUE_MAX));
        add_row(word_row(MODE_VALUE, VALUE_MIN));
        add_row(word_row(MODE_START, '0));
        add_row(word_row(MODE_VALUE, VALUE_MAX));
        add_row(word_row(MODE_VALUE, VALUE_MAX));
        // widest tolerance: stops right after both points, then a stray repeats it
        add_row(setting_row(gss_pkg::CFG_TOLERANCE, TOL_TOP));
        add_row(word_row(MODE_START, '0));
        add_row(word_row(MODE_VALUE, 48'sd7));
        add_row(checked_row(MODE_VALUE, 48'sd9,
                            outcome('0, 1'b1, 32'hFFFE_0000, 32'h0014_0000, 7'd2)));
        add_row(checked_row(MODE_VALUE, -48'sd1,
                            outcome('0, 1'b1, 32'hFFFE_0000, 32'h0014_0000, 7'd2)));
        // empty interval: both points at the same spot
        add_row(setting_row(gss_pkg::CFG_LEFT_START, 32'h4000_0000));
        add_row(setting_row(gss_pkg::CFG_RIGHT_START, 32'h4000_0000));
        add_row(checked_row(MODE_START, '0,
                            outcome(32'h4000_0000, 1'b0, 32'h4000_0000,
                                    32'h4000_0000, 7'd1)));
        add_row(checked_row(MODE_VALUE, 48'sd3,
                            outcome(32'h4000_0000, 1'b0, 32'h4000_0000,
                                    32'h4000_0000, 7'd2)));
        add_row(checked_row(MODE_VALUE, 48'sd3,
                            outcome('0, 1'b1, 32'h4000_0000, 32'h4000_0000, 7'd2)));
        // full coordinate range, tolerance of one
        add_row(setting_row(gss_pkg::CFG_LEFT_START, COORD_MIN));
        add_row(setting_row(gss_pkg::CFG_RIGHT_START, COORD_MAX));
        add_row(setting_row(gss_pkg::CFG_TOLERANCE, 32'd1));
        add_row(word_row(MODE_START, '0));
        add_row(word_row(MODE_VALUE, 48'sd1));
        add_row(word_row(MODE_VALUE, -48'sd1));
        // reversed interval
        add_row(setting_row(gss_pkg::CFG_LEFT_START, COORD_MAX));
        add_row(setting_row(gss_pkg::CFG_RIGHT_START, COORD_MIN));
        add_row(word_row(MODE_START, '0));
        add_row(word_row(MODE_VALUE, -48'sd9));
        add_row(word_row(MODE_VALUE, -48'sd9));
        add_row(word_row(MODE_VALUE, 48'sd4));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_SETTING)
                cfg_write(plan[i].cfg_idx, plan[i].cfg_data);
            else
                send_word(plan[i].mode, plan[i].value, plan[i].pinned, plan[i].result);
        end
        directed_words = words_sent;

        // random phases: cap-bound wide search, reversed full range, then random settings
        while (words_sent - directed_words < RANDOM_WORDS) begin
            case (phase_no)
                0: begin
                    cfg_write(gss_pkg::CFG_LEFT_START, COORD_MIN);
                    cfg_write(gss_pkg::CFG_RIGHT_START, COORD_MAX);
                    cfg_write(gss_pkg::CFG_TOLERANCE, '0);
                end
                1: begin
                    cfg_write(gss_pkg::CFG_LEFT_START, COORD_MAX);
                    cfg_write(gss_pkg::CFG_RIGHT_START, COORD_MIN);
                    cfg_write(gss_pkg::CFG_TOLERANCE, 32'd1);
                end
                default: begin
                    cfg_write(gss_pkg::CFG_LEFT_START, pick_coord());
                    cfg_write(gss_pkg::CFG_RIGHT_START, pick_coord());
                    cfg_write(gss_pkg::CFG_TOLERANCE, pick_tolerance());
                end
            endcase
            searches_left = $urandom_range(2, 5);
            while (searches_left != 0 && words_sent - directed_words < RANDOM_WORDS) begin
                run_search();
                searches_left--;
            end
            phase_no++;
        end

        // drain
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("ran %0d words (%0d from the table) over %0d searches, %0d ran to the end",
                 words_sent, directed_words, searches_started, searches_finished);
        $display("%0d register writes in %0d phases, %0d tie steps, %0d stops on the cap",
                 settings_written, phase_no, tie_steps, cap_stops);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
